@@ rtl/core/fpct_pkg.sv @@
// shared widths, codes and types for the frame pair cache table
`timescale 1ns / 1ps
`default_nettype none

package fpct_pkg;

    // table depth and field widths
    localparam int TABLE_ENTRIES = 16;
    localparam int TAG_W         = 16;
    localparam int FRAME_W       = 32;
    localparam int HANDLE_W      = 32;
    localparam int OP_W          = 2;
    localparam int CLS_W         = 2;

    // command codes
    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    // priority classes that change behavior; any other class is prefetch
    localparam logic [CLS_W-1:0] CLS_EXACT = 2'd0;
    localparam logic [CLS_W-1:0] CLS_SEQ   = 2'd1;

    // payload of one table entry
    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [FRAME_W-1:0]  frame;
        logic                exact;
        logic [HANDLE_W-1:0] handle;
    } t_entry_data;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic clear;    // invalidate every entry
        logic mark;     // flag entries to remove for the incoming insert
        logic compact;  // remove the lowest flagged entry, upper cells slide down
        logic place;    // slide cells up and write the new entry into cell 0
        logic full;     // last cell holds a valid entry
    } t_cell_ctrl;

endpackage

`default_nettype wire

@@ rtl/core/fpct_cell.sv @@
// one table cell: holds the entry of one age rank and trades entries with its neighbors
`timescale 1ns / 1ps
`default_nettype none

module fpct_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire fpct_pkg::t_cell_ctrl          i_ctrl,
    input  wire logic [fpct_pkg::TAG_W-1:0]    i_key_tag,
    input  wire logic [fpct_pkg::FRAME_W-1:0]  i_key_frame,
    input  wire logic                          i_drop_exact,
    input  wire logic                          i_up_valid,
    input  wire logic                          i_up_flag,
    input  wire fpct_pkg::t_entry_data         i_up_data,
    input  wire logic                          i_dn_valid,
    input  wire fpct_pkg::t_entry_data         i_dn_data,
    input  wire logic                          i_drop_seen,
    output logic                               o_drop_seen,
    input  wire logic                          i_exact_above,
    output logic                               o_exact_above,
    input  wire logic                          i_victim_seen,
    output logic                               o_victim_seen,
    output logic                               o_valid,
    output logic                               o_flag,
    output fpct_pkg::t_entry_data              o_data,
    output logic                               o_match,
    output logic [fpct_pkg::HANDLE_W-1:0]      o_hit_handle
);
    import fpct_pkg::*;

    logic        r_valid;
    logic        r_flag;
    t_entry_data r_data;

    logic match;
    logic drop;
    logic victim;
    logic do_compact;
    logic do_shift;

    // key compare and removal decision
    always_comb begin
        match  = r_valid && (r_data.tag == i_key_tag) && (r_data.frame == i_key_frame);
        drop   = match || (i_drop_exact && r_valid && r_data.exact);
        victim = r_valid && !r_data.exact && i_exact_above;
    end

    // neighbor chains: removal point seen below, exact run above, victim seen above
    assign o_drop_seen   = i_drop_seen | r_flag;
    assign o_exact_above = i_exact_above & r_valid & r_data.exact;
    assign o_victim_seen = i_victim_seen | victim;

    assign do_compact = i_ctrl.compact & o_drop_seen;
    assign do_shift   = i_ctrl.place & (~i_ctrl.full | o_victim_seen);

    // valid and removal flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_flag  <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_valid <= 1'b0;
            r_flag  <= 1'b0;
        end else if (i_ctrl.mark) begin
            r_flag  <= drop;
        end else if (do_compact) begin
            r_valid <= i_up_valid;
            r_flag  <= i_up_flag;
        end else if (do_shift) begin
            r_valid <= i_dn_valid;
            r_flag  <= 1'b0;
        end
    end

    // entry payload moves with its valid bit
    always_ff @(posedge i_clk) begin
        if (do_compact) begin
            r_data <= i_up_data;
        end else if (do_shift) begin
            r_data <= i_dn_data;
        end
    end

    assign o_valid      = r_valid;
    assign o_flag       = r_flag;
    assign o_data       = r_data;
    assign o_match      = match;
    assign o_hit_handle = match ? r_data.handle : '0;

endmodule

`default_nettype wire

@@ rtl/core/frame_pair_cache_table.sv @@
// frame pair cache table: fully associative handle table kept as an age-ordered row of cells
//
//  channel  | handshake            | words
//  ---------+----------------------+------------------------------------------------------
//  command  | start / busy         | opcode, context_tag, frame_number, priority_class,
//           |                      | pair_handle
//  result   | o_strobe (1 cycle)   | hit, found_handle, stored
//
// A lookup, clear, no-op or sequential insert gives its result in the cycle after
// acceptance and leaves busy low. Any other insert flags, at acceptance, the entry with
// its key and, for the exact class, every exact entry; it removes one flagged entry at a
// time, the upper cells sliding down, until no flag is left, then slides the row up,
// writes the new entry if there is room and gives its result. Cell 0 holds the newest.
// Reset is synchronous and empties the table; the result side cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module frame_pair_cache_table (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [fpct_pkg::OP_W-1:0]     i_opcode,
    input  wire logic [fpct_pkg::TAG_W-1:0]    i_context_tag,
    input  wire logic [fpct_pkg::FRAME_W-1:0]  i_frame_number,
    input  wire logic [fpct_pkg::CLS_W-1:0]    i_priority_class,
    input  wire logic [fpct_pkg::HANDLE_W-1:0] i_pair_handle,
    output logic                               o_strobe,
    output logic                               o_hit,
    output logic [fpct_pkg::HANDLE_W-1:0]      o_found_handle,
    output logic                               o_stored
);
    import fpct_pkg::*;

    localparam int N = TABLE_ENTRIES;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_PLACE
    } t_state;

    t_state      r_state;
    t_entry_data r_req;
    logic        r_strobe;
    logic        r_hit;
    logic [HANDLE_W-1:0] r_handle;
    logic        r_stored;

    t_cell_ctrl  ctrl;
    logic        accept;
    logic        can_place;
    logic        any_match;
    logic [HANDLE_W-1:0] hit_handle;

    logic [N-1:0]        cell_valid;
    logic [N-1:0]        cell_flag;
    logic [N-1:0]        cell_match;
    t_entry_data         cell_data [N];
    logic [HANDLE_W-1:0] cell_hh [N];
    logic [N:0]          drop_chain;
    logic [N:0]          exact_chain;
    logic [N:0]          victim_chain;

    assign accept = start && (r_state == ST_IDLE);

    // chain ends
    assign drop_chain[0]   = 1'b0;
    assign exact_chain[N]  = 1'b1;
    assign victim_chain[N] = 1'b0;

    // insert proceeds unless the table is full of exact entries
    assign can_place = !cell_valid[N-1] || victim_chain[0];

    // cell control
    always_comb begin
        ctrl.clear   = accept && (i_opcode == OP_CLEAR);
        ctrl.mark    = accept && (i_opcode == OP_INSERT) && (i_priority_class != CLS_SEQ);
        ctrl.compact = (r_state == ST_REMOVE);
        ctrl.place   = (r_state == ST_PLACE) && can_place;
        ctrl.full    = cell_valid[N-1];
    end

    // row of cells
    for (genvar i = 0; i < N; i++) begin : g_cell
        logic        up_valid;
        logic        up_flag;
        t_entry_data up_data;
        logic        dn_valid;
        t_entry_data dn_data;

        if (i == N - 1) begin : g_top
            assign up_valid = 1'b0;
            assign up_flag  = 1'b0;
            assign up_data  = cell_data[i];
        end else begin : g_mid
            assign up_valid = cell_valid[i+1];
            assign up_flag  = cell_flag[i+1];
            assign up_data  = cell_data[i+1];
        end

        if (i == 0) begin : g_head
            assign dn_valid = 1'b1;
            assign dn_data  = r_req;
        end else begin : g_body
            assign dn_valid = cell_valid[i-1];
            assign dn_data  = cell_data[i-1];
        end

        fpct_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (ctrl),
            .i_key_tag     (i_context_tag),
            .i_key_frame   (i_frame_number),
            .i_drop_exact  (i_priority_class == CLS_EXACT),
            .i_up_valid    (up_valid),
            .i_up_flag     (up_flag),
            .i_up_data     (up_data),
            .i_dn_valid    (dn_valid),
            .i_dn_data     (dn_data),
            .i_drop_seen   (drop_chain[i]),
            .o_drop_seen   (drop_chain[i+1]),
            .i_exact_above (exact_chain[i+1]),
            .o_exact_above (exact_chain[i]),
            .i_victim_seen (victim_chain[i+1]),
            .o_victim_seen (victim_chain[i]),
            .o_valid       (cell_valid[i]),
            .o_flag        (cell_flag[i]),
            .o_data        (cell_data[i]),
            .o_match       (cell_match[i]),
            .o_hit_handle  (cell_hh[i])
        );
    end

    // keys are unique in the table, so at most one cell matches
    always_comb begin
        hit_handle = '0;
        for (int k = 0; k < N; k++) begin
            hit_handle = hit_handle | cell_hh[k];
        end
        any_match = |cell_match;
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
            r_hit    <= 1'b0;
            r_handle <= '0;
            r_stored <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            r_hit    <= 1'b0;
            r_handle <= '0;
            r_stored <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (ctrl.mark) begin
                            r_state <= ST_REMOVE;
                        end else begin
                            r_strobe <= 1'b1;
                            if (i_opcode == OP_LOOKUP) begin
                                r_hit    <= any_match;
                                r_handle <= hit_handle;
                            end
                        end
                    end
                end
                ST_REMOVE: begin
                    if (!drop_chain[N]) begin
                        r_state <= ST_PLACE;
                    end
                end
                ST_PLACE: begin
                    r_strobe <= 1'b1;
                    r_stored <= can_place;
                    r_state  <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // request held for the new entry
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.tag    <= i_context_tag;
            r_req.frame  <= i_frame_number;
            r_req.exact  <= (i_priority_class == CLS_EXACT);
            r_req.handle <= i_pair_handle;
        end
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_strobe       = r_strobe;
    assign o_hit          = r_hit;
    assign o_found_handle = r_handle;
    assign o_stored       = r_stored;

endmodule

`default_nettype wire

@@ rtl/core/fpct_checker.sv @@
// port-level checks for the frame pair cache table, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module fpct_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    input  wire logic                          busy,
    input  wire logic [fpct_pkg::OP_W-1:0]     i_opcode,
    input  wire logic [fpct_pkg::CLS_W-1:0]    i_priority_class,
    input  wire logic                          o_strobe,
    input  wire logic                          o_hit,
    input  wire logic [fpct_pkg::HANDLE_W-1:0] o_found_handle,
    input  wire logic                          o_stored
);
    import fpct_pkg::*;

    logic acc;
    logic long_insert;

    assign acc         = start && !busy;
    assign long_insert = (i_opcode == OP_INSERT) && (i_priority_class != CLS_SEQ);

    // a word never reports both a hit and a store
    a_hit_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_hit && o_stored))
        else $error("hit and stored both set");

    // a miss carries a zero handle
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_hit) |-> (o_found_handle == '0))
        else $error("miss with nonzero handle");

    // short commands answer in the next cycle and stay ready
    a_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !long_insert) |=> (o_strobe && !busy))
        else $error("short command result missing");

    // a real insert holds busy and gives no word in the next cycle
    a_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && long_insert) |=> (busy && !o_strobe))
        else $error("insert did not hold busy");

    // busy drops only together with a result word
    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && $past(i_rst_n)) ##1 !busy |-> o_strobe)
        else $error("busy ended without a result");

endmodule

bind frame_pair_cache_table fpct_checker u_fpct_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .i_opcode         (i_opcode),
    .i_priority_class (i_priority_class),
    .o_strobe         (o_strobe),
    .o_hit            (o_hit),
    .o_found_handle   (o_found_handle),
    .o_stored         (o_stored)
);

`default_nettype wire
